// ===== src/qmi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_pkg: shared types and constants
// Word formats, operation and status codes, and slot helpers for the
// linked-list queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

	localparam int CAPACITY    = 1024;
	localparam int POOL_SLOTS  = CAPACITY + 1;
	localparam int SLOT_BITS   = $clog2(CAPACITY + 2);
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 11;

	localparam logic [SLOT_BITS-1:0] NIL_SLOT = SLOT_BITS'(CAPACITY + 1);
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(CAPACITY);
	localparam logic [SLOT_BITS-1:0] POOL_LIMIT = SLOT_BITS'(POOL_SLOTS);
	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(CAPACITY);

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;
	localparam logic [1:0] OP_PEEK   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic [SLOT_BITS-1:0] slot_t;

	typedef struct packed {
		logic [1:0]            operation;
		logic [VALUE_BITS-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value_out;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] count;
	} rsp_word_t;

	typedef struct packed {
		logic  rd_en;
		slot_t rd_addr;
		logic  wr_en;
		slot_t wr_addr;
		slot_t wr_data;
	} link_req_t;

	typedef struct packed {
		logic                  en;
		logic                  we;
		slot_t                 addr;
		logic [VALUE_BITS-1:0] data;
	} pay_req_t;

	// out-of-pool links fall back to the dummy slot
	function automatic slot_t slot_ok(slot_t s);
		return (s < POOL_LIMIT) ? s : '0;
	endfunction

endpackage
`default_nettype wire

// ===== src/qmi_link_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_link_store: slot link memory
// Synchronous link RAM, one read and one write per cycle, read data in
// the following cycle. A fill mark stands in for the initial free chain:
// unwritten slots read as the next slot in line, slot 0 and the last as nil.
// ----------------------------------------------------------------------------
module qmi_link_store
	import qmi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire link_req_t req,
	output logic [SLOT_BITS-1:0] rd_data
);

	slot_t mem [POOL_SLOTS];
	slot_t mem_q;
	slot_t dflt_q;
	logic  wrt_q;
	slot_t hwm_q;
	logic  zero_q;

	logic  wrt;
	slot_t dflt;

	always_comb begin
		if (req.rd_addr == '0) begin
			wrt = zero_q;
		end else begin
			wrt = req.rd_addr < hwm_q;
		end
		if (req.rd_addr == '0 || req.rd_addr == LAST_SLOT) begin
			dflt = NIL_SLOT;
		end else begin
			dflt = req.rd_addr + SLOT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_q  <= mem[req.rd_addr];
			dflt_q <= dflt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrt_q  <= 1'b0;
			hwm_q  <= SLOT_BITS'(1);
			zero_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				wrt_q <= wrt;
			end
			if (req.wr_en) begin
				if (req.wr_addr == '0) begin
					zero_q <= 1'b1;
				end
				if (req.wr_addr == hwm_q) begin
					hwm_q <= hwm_q + SLOT_BITS'(1);
				end
			end
		end
	end

	assign rd_data = wrt_q ? mem_q : dflt_q;

endmodule
`default_nettype wire

// ===== src/qmi_payload_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmi_payload_store: payload word memory
// Single-port synchronous RAM holding one payload word per slot, read
// data registered and returned in the cycle after the request.
// ----------------------------------------------------------------------------
module qmi_payload_store
	import qmi_pkg::*;
(
	input  wire logic     clk,
	input  wire pay_req_t req,
	output logic [VALUE_BITS-1:0] rd_data
);

	logic [VALUE_BITS-1:0] mem [POOL_SLOTS];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.data;
			end else begin
				rd_data <= mem[req.addr];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/queue_with_middle_insert_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core: linked-list queue with middle insertion
// A command passes through S_RD2 and S_WR; the response word is registered
// as S_WR completes, held off while the response is stalled. A new command
// is taken only in S_IDLE, each making up to two reads and two link writes.
// Reset: pointers and count are reset at once; the free chain comes from a
// fill mark, so there is no clearing pass and commands are taken at once.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_core
	import qmi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD2  = 3'b010,
		S_WR   = 3'b100
	} state_t;

	state_t state_q;

	logic [1:0]            op_q;
	logic [VALUE_BITS-1:0] val_q;
	slot_t                 lk1_q;
	slot_t                 head_q;
	slot_t                 mid_q;
	slot_t                 tail_q;
	slot_t                 free_q;
	logic [COUNT_BITS-1:0] cnt_q;
	rsp_word_t             rsp_q;
	logic                  rsp_valid_q;

	link_req_t             link_req;
	slot_t                 link_rd;
	pay_req_t              pay_req;
	logic [VALUE_BITS-1:0] pay_rd;

	logic                  room;
	logic                  do_app;
	logic                  do_mid;
	logic                  do_pop;
	logic                  do_peek;
	logic                  accept;
	logic                  go;
	slot_t                 s_slot;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	rsp_word_t             res;
	slot_t                 head_n;
	slot_t                 mid_n;
	slot_t                 tail_n;
	slot_t                 free_n;
	logic [COUNT_BITS-1:0] cnt_n;

	qmi_link_store u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (link_req),
		.rd_data (link_rd)
	);

	qmi_payload_store u_pay (
		.clk     (clk),
		.req     (pay_req),
		.rd_data (pay_rd)
	);

	assign room    = (cnt_q < COUNT_LIMIT) && (free_q < POOL_LIMIT);
	assign do_app  = (op_q == OP_APPEND) && room;
	assign do_mid  = (op_q == OP_INSERT) && room;
	assign do_pop  = (op_q == OP_POP) && (cnt_q != '0);
	assign do_peek = (op_q == OP_PEEK) && (cnt_q != '0);
	assign s_slot  = slot_ok(free_q);
	assign cnt_inc = cnt_q + COUNT_BITS'(1);
	assign cnt_dec = cnt_q - COUNT_BITS'(1);

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign go        = !rsp_valid_q || !rsp_stall;

	// memory requests
	always_comb begin
		link_req = '0;
		pay_req  = '0;
		case (state_q)
			S_IDLE: begin
				link_req.rd_en = accept;
				if (cmd.operation == OP_INSERT) begin
					link_req.rd_addr = slot_ok(mid_q);
				end else if (cmd.operation == OP_APPEND) begin
					link_req.rd_addr = s_slot;
				end else begin
					link_req.rd_addr = slot_ok(head_q);
				end
			end
			S_RD2: begin
				if (do_app) begin
					link_req.rd_en   = 1'b1;
					link_req.rd_addr = slot_ok(mid_q);
					link_req.wr_en   = 1'b1;
					link_req.wr_addr = s_slot;
					link_req.wr_data = NIL_SLOT;
				end else if (do_mid) begin
					link_req.rd_en   = 1'b1;
					link_req.rd_addr = s_slot;
					link_req.wr_en   = 1'b1;
					link_req.wr_addr = slot_ok(mid_q);
					link_req.wr_data = s_slot;
				end else if (do_pop) begin
					link_req.rd_en   = 1'b1;
					link_req.rd_addr = slot_ok(mid_q);
					link_req.wr_en   = 1'b1;
					link_req.wr_addr = slot_ok(head_q);
					link_req.wr_data = free_q;
				end
				if (do_app || do_mid) begin
					pay_req.en   = 1'b1;
					pay_req.we   = 1'b1;
					pay_req.addr = s_slot;
					pay_req.data = val_q;
				end else if (do_pop || do_peek) begin
					pay_req.en   = 1'b1;
					pay_req.addr = slot_ok(link_rd);
				end
			end
			S_WR: begin
				if (go && do_app) begin
					link_req.wr_en   = 1'b1;
					link_req.wr_addr = slot_ok(tail_q);
					link_req.wr_data = s_slot;
				end else if (go && do_mid) begin
					link_req.wr_en   = 1'b1;
					link_req.wr_addr = s_slot;
					link_req.wr_data = lk1_q;
				end
			end
			default: begin
				link_req = '0;
				pay_req  = '0;
			end
		endcase
	end

	// next queue state and response word
	always_comb begin
		head_n        = head_q;
		mid_n         = mid_q;
		tail_n        = tail_q;
		free_n        = free_q;
		cnt_n         = cnt_q;
		res.value_out = '0;
		res.status    = ST_OK;
		if (do_app) begin
			cnt_n  = cnt_inc;
			free_n = lk1_q;
			tail_n = s_slot;
			if (cnt_inc[0]) begin
				mid_n = (slot_ok(mid_q) == slot_ok(tail_q)) ? s_slot : link_rd;
			end
		end else if (do_mid) begin
			cnt_n  = cnt_inc;
			free_n = link_rd;
			if (cnt_inc <= COUNT_BITS'(2)) begin
				tail_n = s_slot;
			end
			if (cnt_inc[0]) begin
				mid_n = s_slot;
			end
		end else if (do_pop) begin
			cnt_n         = cnt_dec;
			head_n        = slot_ok(lk1_q);
			free_n        = slot_ok(head_q);
			res.value_out = pay_rd;
			if (cnt_dec[0]) begin
				mid_n = link_rd;
			end
		end else if (do_peek) begin
			res.value_out = pay_rd;
		end else if (op_q == OP_APPEND || op_q == OP_INSERT) begin
			res.status = ST_FULL;
		end else begin
			res.status = ST_EMPTY;
		end
		res.count = cnt_n;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.operation;
			val_q <= cmd.value;
		end
		if (state_q == S_RD2) begin
			lk1_q <= link_rd;
		end
		if (state_q == S_WR && go) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			mid_q       <= '0;
			tail_q      <= '0;
			free_q      <= SLOT_BITS'(1);
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_WR && go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (go) begin
						state_q     <= S_IDLE;
						head_q      <= head_n;
						mid_q       <= mid_n;
						tail_q      <= tail_n;
						free_q      <= free_n;
						cnt_q       <= cnt_n;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
